FILE: design/tsc_pkg.sv
// Package for the touch sample conditioner: screen and sample constants,
// register indexes, microcode control word and the read-only microprogram.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package tsc_pkg;

  // Screen geometry and converter resolution.
  localparam int SCREEN_WIDTH  = 240;
  localparam int SCREEN_HEIGHT = 320;
  localparam int SAMPLE_BITS   = 10;

  // Fixed field widths of the channels and registers.
  localparam int SAMPLE_W   = 10;
  localparam int PX_W       = 10;
  localparam int PY_W       = 11;
  localparam int JIT_W      = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);

  // Scaling and division widths follow from the screen size.
  localparam int SIZE_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int Q_W      = $clog2(SIZE_MAX + 1);
  localparam int PROD_W   = SAMPLE_W + Q_W;
  localparam int DIV_BITS = PROD_W;
  localparam int DCNT_W   = $clog2(DIV_BITS);
  localparam int COORD_W  = Q_W + 2;
  localparam int WQ       = 4 * SCREEN_WIDTH;
  localparam int HQ       = 4 * SCREEN_HEIGHT;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_X_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_JITTER   = 3'd6;

  // Datapath operations.
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_WAIT    = 3'd0;
  localparam logic [OP_W-1:0] OP_PAIR    = 3'd1;
  localparam logic [OP_W-1:0] OP_SETUP_X = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV     = 3'd3;
  localparam logic [OP_W-1:0] OP_SETUP_Y = 3'd4;
  localparam logic [OP_W-1:0] OP_COORD   = 3'd5;
  localparam logic [OP_W-1:0] OP_FILTER  = 3'd6;

  // Jump conditions.
  localparam int COND_W = 2;
  localparam logic [COND_W-1:0] COND_NEVER    = 2'd0;
  localparam logic [COND_W-1:0] COND_NO_INPUT = 2'd1;
  localparam logic [COND_W-1:0] COND_DIV_BUSY = 2'd2;
  localparam logic [COND_W-1:0] COND_OUT_BUSY = 2'd3;

  // Program steps.
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_WAIT  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_PAIR  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_SETX  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_DIVX  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_SETY  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_DIVY  = 3'd5;
  localparam logic [STEP_W-1:0] STEP_COORD = 3'd6;
  localparam logic [STEP_W-1:0] STEP_FILT  = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] target;
  } ctl_word_t;

  typedef struct packed {
    logic div_busy;
    logic out_busy;
  } dp_status_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] spread_x;
    logic [SAMPLE_W-1:0] spread_y;
    logic [SAMPLE_W-1:0] x_min;
    logic [SAMPLE_W-1:0] x_max;
    logic [SAMPLE_W-1:0] y_min;
    logic [SAMPLE_W-1:0] y_max;
    logic [JIT_W-1:0]    jitter;
  } cfg_t;

  // Microprogram: a taken condition jumps to the target, else the next step.
  // The last step falls through to step zero by counter wrap.
  function automatic ctl_word_t ucode_rom(input logic [STEP_W-1:0] step);
    ctl_word_t w;
    w = '{op: OP_WAIT, cond: COND_NEVER, target: STEP_WAIT};
    case (step)
      STEP_WAIT:  w = '{op: OP_WAIT,    cond: COND_NO_INPUT, target: STEP_WAIT};
      STEP_PAIR:  w = '{op: OP_PAIR,    cond: COND_NEVER,    target: STEP_WAIT};
      STEP_SETX:  w = '{op: OP_SETUP_X, cond: COND_NEVER,    target: STEP_WAIT};
      STEP_DIVX:  w = '{op: OP_DIV,     cond: COND_DIV_BUSY, target: STEP_DIVX};
      STEP_SETY:  w = '{op: OP_SETUP_Y, cond: COND_NEVER,    target: STEP_WAIT};
      STEP_DIVY:  w = '{op: OP_DIV,     cond: COND_DIV_BUSY, target: STEP_DIVY};
      STEP_COORD: w = '{op: OP_COORD,   cond: COND_NEVER,    target: STEP_WAIT};
      STEP_FILT:  w = '{op: OP_FILTER,  cond: COND_OUT_BUSY, target: STEP_FILT};
      default:    w = '{op: OP_WAIT,    cond: COND_NO_INPUT, target: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: design/tsc_if.sv
// Channel interfaces of the touch sample conditioner: raw sample input and
// filtered point output, each with valid, ready and payload.
// Depends on tsc_pkg for the field widths.
`default_nettype none

interface tsc_in_if;
  import tsc_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] x_sample_a;
  logic [SAMPLE_W-1:0] x_sample_b;
  logic [SAMPLE_W-1:0] x_sample_c;
  logic [SAMPLE_W-1:0] y_sample_a;
  logic [SAMPLE_W-1:0] y_sample_b;
  logic [SAMPLE_W-1:0] y_sample_c;

  modport source (
    output valid, x_sample_a, x_sample_b, x_sample_c, y_sample_a, y_sample_b, y_sample_c,
    input  ready
  );
  modport sink (
    input  valid, x_sample_a, x_sample_b, x_sample_c, y_sample_a, y_sample_b, y_sample_c,
    output ready
  );
endinterface

interface tsc_out_if;
  import tsc_pkg::*;

  logic            valid;
  logic            ready;
  logic [PX_W-1:0] point_x;
  logic [PY_W-1:0] point_y;
  logic            point_accepted;
  logic            spread_ok;

  modport source (
    output valid, point_x, point_y, point_accepted, spread_ok,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_accepted, spread_ok,
    output ready
  );
endinterface

`default_nettype wire

FILE: design/touch_sample_conditioner_core.sv
// Touch sample conditioner: one item of three raw X/Y sample pairs gives
// one filtered quarter-pixel point. An item takes one step each to take
// the samples, average the closest pairs, set up each axis, form the
// coordinates and run the jitter filter, plus two passes of the shared
// bit-serial divider that scales X and Y. The result sits in an output
// register, so the next item is already at work while it waits; only the
// filter step waits for that register to free up. Registers are to be
// written over the cfg_ port only while the block is idle, which the block
// does not enforce; a write to an unused index is dropped.
`default_nettype none

module touch_sample_conditioner_core (
  input  logic                           clk,
  input  logic                           rst_n,
  tsc_in_if.sink                         in_ch,
  tsc_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [tsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tsc_pkg::*;

  cfg_t       cfg_r;
  ctl_word_t  ctl;
  dp_status_t dp_stat;
  logic       in_fire;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.spread_x <= 10'd24;
      cfg_r.spread_y <= 10'd24;
      cfg_r.x_min    <= 10'd100;
      cfg_r.x_max    <= 10'd955;
      cfg_r.y_min    <= 10'd70;
      cfg_r.y_max    <= 10'd925;
      cfg_r.jitter   <= 11'd25;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPREAD_X: cfg_r.spread_x <= cfg_data[SAMPLE_W-1:0];
        REG_SPREAD_Y: cfg_r.spread_y <= cfg_data[SAMPLE_W-1:0];
        REG_X_MIN:    cfg_r.x_min    <= cfg_data[SAMPLE_W-1:0];
        REG_X_MAX:    cfg_r.x_max    <= cfg_data[SAMPLE_W-1:0];
        REG_Y_MIN:    cfg_r.y_min    <= cfg_data[SAMPLE_W-1:0];
        REG_Y_MAX:    cfg_r.y_max    <= cfg_data[SAMPLE_W-1:0];
        REG_JITTER:   cfg_r.jitter   <= cfg_data[JIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input is taken only in the wait step of the program, never during reset.
  assign in_ch.ready = rst_n && (ctl.op == OP_WAIT);
  assign in_fire     = in_ch.valid && in_ch.ready;

  tsc_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .dp_stat  (dp_stat),
    .ctl      (ctl)
  );

  tsc_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .cfg           (cfg_r),
    .in_fire       (in_fire),
    .in_xa         (in_ch.x_sample_a),
    .in_xb         (in_ch.x_sample_b),
    .in_xc         (in_ch.x_sample_c),
    .in_ya         (in_ch.y_sample_a),
    .in_yb         (in_ch.y_sample_b),
    .in_yc         (in_ch.y_sample_c),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_x         (out_ch.point_x),
    .out_y         (out_ch.point_y),
    .out_accepted  (out_ch.point_accepted),
    .out_spread_ok (out_ch.spread_ok),
    .dp_stat       (dp_stat)
  );

  // After an input transfer the block takes no further item until it is done.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("second input transfer while an item is at work");

endmodule

`default_nettype wire

FILE: design/tsc_sequencer.sv
// Microcode sequencer: step counter, control word lookup in the read-only
// program and conditional jumps. Depends on tsc_pkg.
`default_nettype none

module tsc_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  tsc_pkg::dp_status_t dp_stat,
  output tsc_pkg::ctl_word_t  ctl
);
  import tsc_pkg::*;

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  logic              jump;

  assign ctl = ucode_rom(step_r);

  // Evaluate the jump condition of the current control word.
  always_comb begin
    case (ctl.cond)
      COND_NEVER:    jump = 1'b0;
      COND_NO_INPUT: jump = !in_valid;
      COND_DIV_BUSY: jump = dp_stat.div_busy;
      COND_OUT_BUSY: jump = dp_stat.out_busy;
      default:       jump = 1'b0;
    endcase
    step_nxt = jump ? ctl.target : step_r + STEP_W'(1);
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/tsc_datapath.sv
// Datapath of the touch sample conditioner: closest-pair averaging, axis
// scaling with a shared restoring divider, and the jitter filter with its
// history. Driven by the sequencer's control word; depends on tsc_pkg.
`default_nettype none

module tsc_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tsc_pkg::ctl_word_t           ctl,
  input  tsc_pkg::cfg_t                cfg,
  input  logic                         in_fire,
  input  logic [tsc_pkg::SAMPLE_W-1:0] in_xa,
  input  logic [tsc_pkg::SAMPLE_W-1:0] in_xb,
  input  logic [tsc_pkg::SAMPLE_W-1:0] in_xc,
  input  logic [tsc_pkg::SAMPLE_W-1:0] in_ya,
  input  logic [tsc_pkg::SAMPLE_W-1:0] in_yb,
  input  logic [tsc_pkg::SAMPLE_W-1:0] in_yc,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [tsc_pkg::PX_W-1:0]     out_x,
  output logic [tsc_pkg::PY_W-1:0]     out_y,
  output logic                         out_accepted,
  output logic                         out_spread_ok,
  output tsc_pkg::dp_status_t          dp_stat
);
  import tsc_pkg::*;

  // Average of the closest pair of three samples, plus a spread check.
  function automatic logic [SAMPLE_W:0] best_pair(
    input logic [SAMPLE_W-1:0] a,
    input logic [SAMPLE_W-1:0] b,
    input logic [SAMPLE_W-1:0] c,
    input logic [SAMPLE_W-1:0] lim
  );
    logic [SAMPLE_W-1:0] d0, d1, d2;
    logic [SAMPLE_W:0]   sum;
    logic                ok;
    d0 = (a > b) ? a - b : b - a;
    d1 = (b > c) ? b - c : c - b;
    d2 = (c > a) ? c - a : a - c;
    if (d0 < d1) begin
      sum = (d2 < d0) ? {1'b0, a} + {1'b0, c} : {1'b0, a} + {1'b0, b};
    end else if (d2 < d1) begin
      sum = {1'b0, a} + {1'b0, c};
    end else begin
      sum = {1'b0, b} + {1'b0, c};
    end
    ok = !((d0 > lim) || (d1 > lim) || (d2 > lim));
    return {ok, sum[SAMPLE_W:1]};
  endfunction

  // Latched input samples.
  logic [SAMPLE_W-1:0] xa_r, xb_r, xc_r, ya_r, yb_r, yc_r;
  // Averaged raw values and spread flag.
  logic [SAMPLE_W-1:0] rx_r, ry_r;
  logic                ok_r;
  // Divider state.
  logic [PROD_W-1:0]   dvd_r;
  logic [SAMPLE_W-1:0] rem_r;
  logic [SAMPLE_W-1:0] dsr_r;
  logic                empty_r;
  logic [DCNT_W-1:0]   div_cnt_r;
  logic [Q_W-1:0]      qx_r;
  // Screen coordinates of the current point.
  logic [PX_W-1:0]     px_r;
  logic [PY_W-1:0]     py_r;
  // Jitter history; entry 1 is the newest.
  logic [1:0]          history_count_r, history_count_nxt;
  logic [PX_W-1:0]     hx0_r, hx1_r;
  logic [PY_W-1:0]     hy0_r, hy1_r;
  // Output register.
  logic                out_valid_r;
  logic [PX_W-1:0]     out_x_r;
  logic [PY_W-1:0]     out_y_r;
  logic                out_acc_r;
  logic                out_ok_r;

  logic [SAMPLE_W:0]   pair_x, pair_y;
  logic                setup_y;
  logic [SAMPLE_W-1:0] ax_v, ax_lo, ax_hi, ax_clamp, ax_off;
  logic [Q_W-1:0]      ax_size;
  logic [PROD_W-1:0]   ax_prod;
  logic [SAMPLE_W:0]   rem_sh;
  logic                rem_ge;
  logic [SAMPLE_W:0]   rem_sub;
  logic [Q_W-1:0]      quot;
  logic [COORD_W-1:0]  px_w, py_w;
  logic [PX_W-1:0]     tx, dx;
  logic [PY_W-1:0]     ty, dy;
  logic [PX_W:0]       tx_sum;
  logic [PY_W:0]       ty_sum;
  logic                out_free;
  logic                filt_go;
  logic                check;
  logic                reject;

  // Closest-pair averaging of both axes.
  assign pair_x = best_pair(xa_r & SAMPLE_MASK, xb_r & SAMPLE_MASK, xc_r & SAMPLE_MASK,
                            cfg.spread_x);
  assign pair_y = best_pair(ya_r & SAMPLE_MASK, yb_r & SAMPLE_MASK, yc_r & SAMPLE_MASK,
                            cfg.spread_y);

  // Axis setup: clamp to the maximum, floor the offset at zero, scale.
  always_comb begin
    setup_y  = (ctl.op == OP_SETUP_Y);
    ax_v     = setup_y ? ry_r : rx_r;
    ax_lo    = setup_y ? cfg.y_min : cfg.x_min;
    ax_hi    = setup_y ? cfg.y_max : cfg.x_max;
    ax_size  = setup_y ? Q_W'(SCREEN_HEIGHT) : Q_W'(SCREEN_WIDTH);
    ax_clamp = (ax_v >= ax_hi) ? ax_hi : ax_v;
    ax_off   = (ax_clamp > ax_lo) ? ax_clamp - ax_lo : '0;
    ax_prod  = PROD_W'(ax_off) * PROD_W'(ax_size);
  end

  // One restoring division step; the dividend register collects the quotient.
  always_comb begin
    rem_sh  = {rem_r, dvd_r[PROD_W-1]};
    rem_ge  = (rem_sh >= {1'b0, dsr_r});
    rem_sub = rem_sh - {1'b0, dsr_r};
    quot    = empty_r ? '0 : dvd_r[Q_W-1:0];
  end

  // Coordinates from the two quotients, with Y inverted and edges clamped.
  always_comb begin
    px_w = {qx_r, 2'b00};
    py_w = {Q_W'(SCREEN_HEIGHT) - quot, 2'b00};
    if (px_w >= COORD_W'(WQ)) begin
      px_w = COORD_W'(WQ - 1);
    end
    if (py_w >= COORD_W'(HQ)) begin
      py_w = COORD_W'(HQ - 1);
    end
  end

  // Jitter check against the midpoint of the oldest kept point and the new one.
  always_comb begin
    out_free = !out_valid_r || out_ready;
    filt_go  = (ctl.op == OP_FILTER) && out_free;
    tx_sum   = {1'b0, hx0_r} + {1'b0, px_r};
    ty_sum   = {1'b0, hy0_r} + {1'b0, py_r};
    tx       = tx_sum[PX_W:1];
    ty       = ty_sum[PY_W:1];
    dx       = (hx1_r > tx) ? hx1_r - tx : tx - hx1_r;
    dy       = (hy1_r > ty) ? hy1_r - ty : ty - hy1_r;
    check    = (history_count_r == 2'd2);
    reject   = check && ((JIT_W'(dx) > cfg.jitter) || (JIT_W'(dy) > cfg.jitter));
    if (reject) begin
      history_count_nxt = 2'd0;
    end else if (check) begin
      history_count_nxt = 2'd2;
    end else begin
      history_count_nxt = history_count_r + 2'd1;
    end
  end

  // Payload registers of the datapath.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      xa_r <= in_xa;
      xb_r <= in_xb;
      xc_r <= in_xc;
      ya_r <= in_ya;
      yb_r <= in_yb;
      yc_r <= in_yc;
    end
    case (ctl.op)
      OP_PAIR: begin
        rx_r <= pair_x[SAMPLE_W-1:0];
        ry_r <= pair_y[SAMPLE_W-1:0];
        ok_r <= pair_x[SAMPLE_W] && pair_y[SAMPLE_W];
      end
      OP_SETUP_X, OP_SETUP_Y: begin
        if (setup_y) begin
          qx_r <= quot;
        end
        dvd_r   <= ax_prod;
        rem_r   <= '0;
        dsr_r   <= ax_hi - ax_lo;
        empty_r <= (ax_hi <= ax_lo);
      end
      OP_DIV: begin
        dvd_r <= {dvd_r[PROD_W-2:0], rem_ge};
        rem_r <= rem_ge ? rem_sub[SAMPLE_W-1:0] : rem_sh[SAMPLE_W-1:0];
      end
      OP_COORD: begin
        px_r <= px_w[PX_W-1:0];
        py_r <= PY_W'(py_w);
      end
      default: begin
      end
    endcase
    if (filt_go) begin
      out_x_r   <= reject ? hx1_r : px_r;
      out_y_r   <= reject ? hy1_r : py_r;
      out_acc_r <= check && !reject;
      out_ok_r  <= ok_r;
    end
  end

  // Control registers: division counter, history and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r       <= '0;
      history_count_r <= 2'd0;
      hx0_r           <= '0;
      hx1_r           <= '0;
      hy0_r           <= '0;
      hy1_r           <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if ((ctl.op == OP_SETUP_X) || (ctl.op == OP_SETUP_Y)) begin
        div_cnt_r <= DCNT_W'(DIV_BITS - 1);
      end else if ((ctl.op == OP_DIV) && (div_cnt_r != '0)) begin
        div_cnt_r <= div_cnt_r - DCNT_W'(1);
      end
      if (filt_go) begin
        history_count_r <= history_count_nxt;
        if (!reject) begin
          hx0_r <= hx1_r;
          hy0_r <= hy1_r;
          hx1_r <= px_r;
          hy1_r <= py_r;
        end
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign dp_stat.div_busy = (div_cnt_r != '0);
  assign dp_stat.out_busy = !out_free;

  assign out_valid     = out_valid_r;
  assign out_x         = out_x_r;
  assign out_y         = out_y_r;
  assign out_accepted  = out_acc_r;
  assign out_spread_ok = out_ok_r;

  // The warm-up count never leaves the range zero to two.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    history_count_r != 2'd3)
    else $error("history count out of range");

  // A rejected point leaves the history alone and restarts warm-up.
  a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (filt_go && reject) |=> (history_count_r == 2'd0) && $stable(hx1_r) && $stable(hy1_r)
      && $stable(hx0_r) && $stable(hy0_r))
    else $error("rejection changed the history");

  // A new result only appears after the filter step.
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctl.op == OP_FILTER))
    else $error("result raised outside the filter step");

endmodule

`default_nettype wire
